/* src/cps_pkg.sv */
// cps_pkg: shared types and constants of the contour point smoother
// depends on nothing; used by every module under src
package cps_pkg;

    localparam int COORD_W     = 20;
    localparam int FRAC_W      = 4;
    localparam int WEIGHT_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = WEIGHT_W;

    // accumulator and divider sizing, bounded by three weighted distances
    localparam int MAX_DIST    = 3;
    localparam int DIST_W      = 2;
    localparam int UNIT_WEIGHT = 8;
    localparam int NUM_W       = 28;
    localparam int DEN_W       = 7;
    localparam int QUO_W       = COORD_W - FRAC_W;
    localparam int QCNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FAR  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_NEAR_RST = 4'd7;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MID_RST  = 4'd6;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FAR_RST  = 4'd5;

    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

/* src/cps_cell.sv */
// cps_cell: one storage cell of the point chain
// depends on cps_pkg (point_t)
module cps_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  cps_pkg::point_t din,
    output cps_pkg::point_t dout
);

    cps_pkg::point_t pt_reg;

    // takes the upper neighbor's point on every chain shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            pt_reg <= din;
        end
    end

    assign dout = pt_reg;

endmodule

/* src/cps_divider.sv */
// cps_divider: bit-serial signed divide of a weighted sum by sixteen times its weight
// depends on cps_pkg (widths); gives the whole-coordinate quotient truncated toward zero
module cps_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cps_pkg::NUM_W-1:0]  dividend,
    input  logic [cps_pkg::DEN_W-1:0]         den,
    output logic                              busy,
    output logic signed [cps_pkg::QUO_W-1:0]  quotient
);

    localparam int NUM_W = cps_pkg::NUM_W;
    localparam int QUO_W = cps_pkg::QUO_W;
    localparam int DSH_W = cps_pkg::DEN_W + cps_pkg::FRAC_W + QUO_W - 1;

    logic                        busy_reg, busy_next;
    logic [cps_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]            rem_reg, rem_next;
    logic [DSH_W-1:0]            dsh_reg, dsh_next;
    logic [QUO_W-1:0]            quo_reg, quo_next;
    logic                        neg_reg, neg_next;
    logic [NUM_W-1:0]            dsh_ext;
    logic                        fit;

    assign dsh_ext = NUM_W'(dsh_reg);
    assign fit     = rem_reg >= dsh_ext;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // magnitude stays below the divisor times two to the quotient width
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[NUM_W-1];
            rem_next  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            dsh_next  = DSH_W'({den, {cps_pkg::FRAC_W{1'b0}}}) << (QUO_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? rem_reg - dsh_ext : rem_reg;
            quo_next = {quo_reg[QUO_W-2:0], fit};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cps_pkg::QCNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

/* src/contour_point_smoother_core.sv */
// contour_point_smoother_core: top level of the contour point smoother
// depends on cps_pkg, cps_cell (point chain) and cps_divider (one per coordinate)
//
// Collects a run of (x, y) points up to the request marked last_point and then
// returns the same number of points, out_last on the final one. The first and
// last points come back unchanged, as do all points of runs of HALF_TAPS+3 or
// fewer; every other point becomes the average of itself (weight one) and its
// neighbors up to three places away on each side that lie inside the run, with
// weight_near/weight_mid/weight_far in eighths, renormalized by the weights
// present and truncated toward zero to a whole coordinate. Points beyond
// MAX_POINTS are dropped, though a dropped last point still ends the run.
// Timing: one point is taken per cycle while the run loads. After the last
// point the chain is rolled until the first point sits in the center cell
// of HALF_TAPS+UPPER cells, UPPER being MAX_POINTS (at least HALF_TAPS+1);
// then an unchanged point passes through pick and emit, a smoothed point through
// pick, accumulate, the one-bit-per-cycle divider (16 steps) and emit. A result
// waiting on res_ready holds emission but not the loading of the next run,
// which starts as soon as the final result of a run has been registered. The
// user writes weight registers with cfg_we while the block is idle (unchecked).
module contour_point_smoother_core #(
    parameter int MAX_POINTS = 8,
    parameter int HALF_TAPS  = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // weight registers
    input  logic                                  cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]        cfg_data,
    // point requests
    input  logic                                  pt_valid,
    output logic                                  pt_ready,
    input  logic signed [cps_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [cps_pkg::COORD_W-1:0]    y_coord,
    input  logic                                  last_point,
    // result requests
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [cps_pkg::COORD_W-1:0]    out_x,
    output logic signed [cps_pkg::COORD_W-1:0]    out_y,
    output logic                                  out_last
);

    localparam int COORD_W   = cps_pkg::COORD_W;
    localparam int NUM_W     = cps_pkg::NUM_W;
    localparam int DEN_W     = cps_pkg::DEN_W;
    localparam int DIST_W    = cps_pkg::DIST_W;
    localparam int PROD_W    = COORD_W + cps_pkg::WEIGHT_W + 2;

    // the chain needs room above the center for a full run and for the right taps
    localparam int UPPER     = (MAX_POINTS > HALF_TAPS + 1) ? MAX_POINTS : HALF_TAPS + 1;
    localparam int CHAIN_LEN = HALF_TAPS + UPPER;
    localparam int CNT_W     = $clog2(UPPER + 1);
    localparam int TAPS_USED = (HALF_TAPS < cps_pkg::MAX_DIST) ? HALF_TAPS : cps_pkg::MAX_DIST;
    localparam int CENTER    = HALF_TAPS;

    // tap cells; distances beyond TAPS_USED are never selected
    localparam int LEFT1     = CENTER - 1;
    localparam int LEFT2     = (HALF_TAPS >= 2) ? CENTER - 2 : 0;
    localparam int LEFT3     = (HALF_TAPS >= 3) ? CENTER - 3 : 0;
    localparam int RIGHT1    = CENTER + 1;
    localparam int RIGHT2    = (HALF_TAPS >= 2) ? CENTER + 2 : CENTER;
    localparam int RIGHT3    = (HALF_TAPS >= 3) ? CENTER + 3 : CENTER;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_PRE    = 3'd1;
    localparam logic [2:0] ST_PICK   = 3'd2;
    localparam logic [2:0] ST_ACC    = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DWAIT  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    // control state
    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic                     smooth_reg, smooth_next;
    logic                     res_valid_reg, res_valid_next;

    // weight registers
    cps_pkg::weight_t         w_near_reg, w_mid_reg, w_far_reg;

    // accumulators and result payload
    logic signed [NUM_W-1:0]   num_x_reg, num_x_next;
    logic signed [NUM_W-1:0]   num_y_reg, num_y_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic signed [COORD_W-1:0] out_x_reg, out_x_next;
    logic signed [COORD_W-1:0] out_y_reg, out_y_next;
    logic                      out_last_reg, out_last_next;

    // chain
    cps_pkg::point_t          chain [CHAIN_LEN];
    cps_pkg::point_t          new_pt;
    cps_pkg::point_t          center_pt, left_pt, right_pt;
    logic                     chain_shift;

    // tap arithmetic
    cps_pkg::weight_t               tap_w;
    logic                           left_in, right_in;
    logic signed [COORD_W:0]        pair_x, pair_y;
    logic signed [PROD_W-1:0]       term_x, term_y;
    logic [DEN_W-1:0]               wsum;

    // divider
    logic                            div_start;
    logic                            div_busy_x, div_busy_y;
    logic signed [cps_pkg::QUO_W-1:0] quo_x, quo_y;

    // handshake helpers
    logic                     slot_free;
    logic                     not_full;
    logic [CNT_W-1:0]         count_after;
    logic                     run_smooth;
    logic                     is_final;

    assign new_pt = '{x: x_coord, y: y_coord};

    // row of cells; points enter at the top and move down one cell per shift
    for (genvar c = 0; c < CHAIN_LEN; c++)
    begin : g_cell
        cps_pkg::point_t cell_in;
        if (c == CHAIN_LEN - 1)
        begin : g_top
            assign cell_in = new_pt;
        end
        else
        begin : g_mid
            assign cell_in = chain[c+1];
        end
        cps_cell u_cell (
            .clk      (clk),
            .shift_en (chain_shift),
            .din      (cell_in),
            .dout     (chain[c])
        );
    end

    assign center_pt = chain[CENTER];

    // neighbor pair and weight of the distance now being summed
    always_comb
    begin
        case (dist_reg)
            2'd1:
            begin
                left_pt  = chain[LEFT1];
                right_pt = chain[RIGHT1];
                tap_w    = w_near_reg;
            end
            2'd2:
            begin
                left_pt  = chain[LEFT2];
                right_pt = chain[RIGHT2];
                tap_w    = w_mid_reg;
            end
            2'd3:
            begin
                left_pt  = chain[LEFT3];
                right_pt = chain[RIGHT3];
                tap_w    = w_far_reg;
            end
            default:
            begin
                left_pt  = center_pt;
                right_pt = center_pt;
                tap_w    = '0;
            end
        endcase
    end

    // a neighbor counts only when it lies inside the run
    assign left_in  = {1'b0, idx_reg} >= (CNT_W+1)'(dist_reg);
    assign right_in = ({1'b0, idx_reg} + (CNT_W+1)'(dist_reg)) < {1'b0, count_reg};

    assign pair_x = (left_in  ? (COORD_W+1)'(left_pt.x)  : '0)
                  + (right_in ? (COORD_W+1)'(right_pt.x) : '0);
    assign pair_y = (left_in  ? (COORD_W+1)'(left_pt.y)  : '0)
                  + (right_in ? (COORD_W+1)'(right_pt.y) : '0);
    assign term_x = $signed({1'b0, tap_w}) * pair_x;
    assign term_y = $signed({1'b0, tap_w}) * pair_y;
    assign wsum   = (left_in  ? DEN_W'(tap_w) : '0)
                  + (right_in ? DEN_W'(tap_w) : '0);

    assign slot_free   = !res_valid_reg || res_ready;
    assign not_full    = count_reg < CNT_W'(MAX_POINTS);
    assign count_after = count_reg + CNT_W'(not_full);
    assign run_smooth  = 32'(count_reg) > 32'(HALF_TAPS + 3);
    assign is_final    = idx_reg == (count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        dist_next      = dist_reg;
        smooth_next    = smooth_reg;
        num_x_next     = num_x_reg;
        num_y_next     = num_y_reg;
        den_next       = den_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        res_valid_next = res_valid_reg && !res_ready;
        chain_shift    = 1'b0;
        div_start      = 1'b0;
        pt_ready       = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                pt_ready = 1'b1;
                if (pt_valid)
                begin
                    // full store: the point is dropped
                    chain_shift = not_full;
                    count_next  = count_after;
                    if (last_point)
                    begin
                        idx_next   = count_after;
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE:
            begin
                // roll until the first point sits in the center cell
                if (idx_reg == CNT_W'(UPPER))
                begin
                    idx_next   = '0;
                    state_next = ST_PICK;
                end
                else
                begin
                    chain_shift = 1'b1;
                    idx_next    = idx_reg + CNT_W'(1);
                end
            end
            ST_PICK:
            begin
                smooth_next = run_smooth && (idx_reg != '0) && !is_final;
                if (run_smooth && (idx_reg != '0) && !is_final)
                begin
                    num_x_next = NUM_W'(center_pt.x) <<< 3;
                    num_y_next = NUM_W'(center_pt.y) <<< 3;
                    den_next   = DEN_W'(cps_pkg::UNIT_WEIGHT);
                    dist_next  = DIST_W'(1);
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ACC:
            begin
                num_x_next = num_x_reg + NUM_W'(term_x);
                num_y_next = num_y_reg + NUM_W'(term_y);
                den_next   = den_reg + wsum;
                dist_next  = dist_reg + DIST_W'(1);
                if (dist_reg == DIST_W'(TAPS_USED))
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (!div_busy_x && !div_busy_y)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    out_last_next  = is_final;
                    if (smooth_reg)
                    begin
                        out_x_next = {quo_x, {cps_pkg::FRAC_W{1'b0}}};
                        out_y_next = {quo_y, {cps_pkg::FRAC_W{1'b0}}};
                    end
                    else
                    begin
                        out_x_next = center_pt.x;
                        out_y_next = center_pt.y;
                    end
                    if (is_final)
                    begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        chain_shift = 1'b1;
                        idx_next    = idx_reg + CNT_W'(1);
                        state_next  = ST_PICK;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    cps_divider u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_x_reg),
        .den      (den_reg),
        .busy     (div_busy_x),
        .quotient (quo_x)
    );

    cps_divider u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_y_reg),
        .den      (den_reg),
        .busy     (div_busy_y),
        .quotient (quo_y)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            dist_reg      <= '0;
            smooth_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            dist_reg      <= dist_next;
            smooth_reg    <= smooth_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // weight registers, upper indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_near_reg <= cps_pkg::WEIGHT_NEAR_RST;
            w_mid_reg  <= cps_pkg::WEIGHT_MID_RST;
            w_far_reg  <= cps_pkg::WEIGHT_FAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cps_pkg::REG_WEIGHT_NEAR: w_near_reg <= cfg_data;
                cps_pkg::REG_WEIGHT_MID:  w_mid_reg  <= cfg_data;
                cps_pkg::REG_WEIGHT_FAR:  w_far_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        num_x_reg    <= num_x_next;
        num_y_reg    <= num_y_next;
        den_reg      <= den_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign res_valid = res_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

/* tb/tb_contour_point_smoother_core.sv */
// tb_contour_point_smoother_core: self-checking testbench for the contour point smoother
// depends on cps_pkg and contour_point_smoother_core; directed runs first, then random
// runs under several weight settings and idle patterns on both request channels

module tb_contour_point_smoother_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = cps_pkg::COORD_W;
    localparam int CFG_IDX_W   = cps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = cps_pkg::CFG_DATA_W;
    localparam int FRAC_W      = cps_pkg::FRAC_W;
    localparam int UNIT_WEIGHT = cps_pkg::UNIT_WEIGHT;

    // same sizing as the block defaults, passed down explicitly
    localparam int POINT_CAP = 8;
    localparam int HALF_SPAN = 3;

    // runs of this many points or fewer come back untouched
    localparam int SHORT_RUN = HALF_SPAN + 3;

    // quiet time after the final result of a run before the weights are touched
    localparam int SETTLE_CYCLES = 40;

    // cycles with no request accepted on either side before the simulation is stopped as failed
    localparam int STALL_LIMIT = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

    typedef struct {
        cps_pkg::point_t pt;
        logic            fin;
    } smoothed_point_t;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     cfg_data   = '0;
    logic                      pt_valid   = 1'b0;
    logic                      pt_ready;
    logic signed [COORD_W-1:0] x_coord    = '0;
    logic signed [COORD_W-1:0] y_coord    = '0;
    logic                      last_point = 1'b0;
    logic                      res_valid;
    logic                      res_ready  = 1'b0;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      out_last;

    // our own copy of the weight registers, starting at their reset values
    cps_pkg::weight_t tap_near = cps_pkg::WEIGHT_NEAR_RST;
    cps_pkg::weight_t tap_mid  = cps_pkg::WEIGHT_MID_RST;
    cps_pkg::weight_t tap_far  = cps_pkg::WEIGHT_FAR_RST;

    // points of the run being loaded, as the block should hold them
    logic signed [COORD_W-1:0] held_x [POINT_CAP];
    logic signed [COORD_W-1:0] held_y [POINT_CAP];
    int                        held_count = 0;

    smoothed_point_t expected_points [$];

    int fault_count    = 0;
    int points_sent    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    contour_point_smoother_core #(
        .MAX_POINTS (POINT_CAP),
        .HALF_TAPS  (HALF_SPAN)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pt_valid   (pt_valid),
        .pt_ready   (pt_ready),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .last_point (last_point),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_last   (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // weight of a neighbor at distance d; nothing past the third neighbor counts
    function automatic longint tap_weight(input int d);
        case (d)
            1:       return longint'(tap_near);
            2:       return longint'(tap_mid);
            3:       return longint'(tap_far);
            default: return 0;
        endcase
    endfunction

    // weighted mean of point i over the n held points, renormalized by the
    // weights actually present, truncated toward zero to a whole coordinate
    function automatic logic signed [COORD_W-1:0] weighted_mean(
        input logic signed [COORD_W-1:0] pts [POINT_CAP],
        input int                        n,
        input int                        i
    );
        longint acc;
        longint wsum;
        longint w;
        longint scale;
        longint quo;
        acc   = UNIT_WEIGHT * longint'(pts[i]);
        wsum  = UNIT_WEIGHT;
        scale = longint'(1) << FRAC_W;
        for (int d = 1; d <= HALF_SPAN; d++)
        begin
            w = tap_weight(d);
            if (i - d >= 0)
            begin
                acc  += w * longint'(pts[i - d]);
                wsum += w;
            end
            if (i + d < n)
            begin
                acc  += w * longint'(pts[i + d]);
                wsum += w;
            end
        end
        // sv division of signed operands truncates toward zero
        quo = (acc / (scale * wsum)) * scale;
        return quo[COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // result monitor: tracks accepted points and checks every result
    // both handshakes are looked at with their pre-edge values
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        smoothed_point_t want;
        if (rst_n)
        begin
            if (pt_valid && pt_ready)
            begin
                // a full store drops the point, but a final one still closes the run
                if (held_count < POINT_CAP)
                begin
                    held_x[held_count] = x_coord;
                    held_y[held_count] = y_coord;
                    held_count++;
                end
                if (last_point)
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        want.pt.x = held_x[i];
                        want.pt.y = held_y[i];
                        // end points and short runs pass through
                        if (held_count > SHORT_RUN && i > 0 && i < held_count - 1)
                        begin
                            want.pt.x = weighted_mean(held_x, held_count, i);
                            want.pt.y = weighted_mean(held_y, held_count, i);
                        end
                        want.fin = (i == held_count - 1);
                        expected_points.insert(expected_points.size(), want);
                    end
                    held_count = 0;
                end
            end

            if (res_valid && res_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result request: out_x %0d out_y %0d out_last %0b",
                           out_x, out_y, out_last);
                    fault_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_x !== want.pt.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.pt.x, out_x);
                        fault_count++;
                    end
                    if (out_y !== want.pt.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.pt.y, out_y);
                        fault_count++;
                    end
                    if (out_last !== want.fin)
                    begin
                        $error("out_last: expected %0b, got %0b", want.fin, out_last);
                        fault_count++;
                    end
                end
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: give up once nothing has moved for too long
    always @(posedge clk)
    begin
        if ((pt_valid && pt_ready) || (res_valid && res_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** contour_point_smoother_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one point request; valid stays up after acceptance so back-to-back
    // points need no extra assignment, a gap lowers it first
    task automatic send_point(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      fin
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            pt_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pt_valid   <= 1'b1;
        x_coord    <= px;
        y_coord    <= py;
        last_point <= fin;
        do
            @(posedge clk);
        while (!pt_ready);
        points_sent++;
    endtask

    // hold off the sender until every predicted result is back, then let
    // the block settle so it is idle
    task automatic wait_for_results();
        pt_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller lowers cfg_we after the last one
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            cps_pkg::REG_WEIGHT_NEAR: tap_near = val;
            cps_pkg::REG_WEIGHT_MID:  tap_mid  = val;
            cps_pkg::REG_WEIGHT_FAR:  tap_far  = val;
            default: ;
        endcase
    endtask

    // new weights, only ever with the block drained
    task automatic set_weights(
        input cps_pkg::weight_t wn,
        input cps_pkg::weight_t wm,
        input cps_pkg::weight_t wf
    );
        wait_for_results();
        write_reg(cps_pkg::REG_WEIGHT_NEAR, wn);
        write_reg(cps_pkg::REG_WEIGHT_MID, wm);
        write_reg(cps_pkg::REG_WEIGHT_FAR, wf);
        // spare index, must not disturb the weights
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // next coordinate of a run in one of three flavors:
    // 0 smooth contour walk, 1 any 20-bit value, 2 range corners
    function automatic logic signed [COORD_W-1:0] next_coord(
        input int   flavor,
        inout int   walk
    );
        logic signed [COORD_W-1:0] v;
        case (flavor)
            0:
            begin
                walk += int'($urandom_range(1024)) - 512;
                v = walk[COORD_W-1:0];
            end
            1:
                v = COORD_W'($urandom);
            default:
                case ($urandom_range(3))
                    0:       v = COORD_MAX;
                    1:       v = COORD_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
        endcase
        return v;
    endfunction

    // a random run: mostly long enough to be smoothed, some short ones,
    // some that overflow the store
    task automatic send_random_run(input bit pause_after);
        int pick;
        int len;
        int flavor;
        int walk_x;
        int walk_y;
        pick = $urandom_range(99);
        if (pick < 60)
            len = $urandom_range(POINT_CAP, SHORT_RUN + 1);
        else if (pick < 85)
            len = $urandom_range(SHORT_RUN, 1);
        else
            len = $urandom_range(POINT_CAP + 3, POINT_CAP + 1);
        pick = $urandom_range(9);
        flavor = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
        walk_x = int'($urandom_range(800000)) - 400000;
        walk_y = int'($urandom_range(800000)) - 400000;
        for (int k = 0; k < len; k++)
        begin
            send_point(next_coord(flavor, walk_x), next_coord(flavor, walk_y),
                       k == len - 1);
        end
        if (pause_after)
            wait_for_results();
    endtask

    // random runs until the phase has sent its share of points; the first
    // run always ends with the sender waiting for every result
    task automatic random_runs(input int quota);
        int first;
        first = points_sent;
        send_random_run(1'b1);
        while (points_sent - first < quota)
            send_random_run($urandom_range(3) == 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // single point and a run at the short-run limit, reset weights
    task automatic test_pass_through_runs();
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(-20'sd1, 20'sd1, 1'b0);
        send_point(20'sh0000F, -20'sd17, 1'b0);
        send_point(20'sh2AAAA, 20'sh55555, 1'b0);
        send_point(20'shD5555, 20'shAAAAA, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
    endtask

    // shortest run that is smoothed: x swings between the range corners,
    // y is small and negative with fraction bits so truncation goes toward zero
    task automatic test_interior_smoothing();
        for (int k = 0; k < SHORT_RUN + 1; k++)
        begin
            send_point(k[0] ? COORD_MIN : COORD_MAX, COORD_W'(-(k * 13 + 5)),
                       k == SHORT_RUN);
        end
    endtask

    // two points past capacity, the final one among the dropped
    task automatic test_store_overflow();
        for (int k = 0; k < POINT_CAP + 2; k++)
        begin
            send_point(COORD_W'($urandom), COORD_W'($urandom), k == POINT_CAP + 1);
        end
    endtask

    // weights above the nominal range, no idling on either side
    task automatic test_weight_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_weights(4'd15, 4'd15, 4'd15);
        random_runs(26);
    endtask

    // all neighbor weights zero, sender mostly idle
    task automatic test_sender_gaps();
        set_weights(4'd0, 4'd0, 4'd0);
        send_idle_pct  = 80;
        recv_stall_pct = 0;
        random_runs(26);
    endtask

    // full-unit weights, receiver mostly stalled
    task automatic test_receiver_stalls();
        set_weights(4'd8, 4'd8, 4'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        random_runs(26);
    endtask

    // light idling on both sides, uneven and then random weights
    task automatic test_mixed_idling();
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        set_weights(4'd1, 4'd0, 4'd8);
        random_runs(13);
        set_weights(cps_pkg::weight_t'($urandom), cps_pkg::weight_t'($urandom),
                    cps_pkg::weight_t'($urandom));
        random_runs(13);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pass_through_runs();
        test_interior_smoothing();
        test_store_overflow();
        test_weight_extremes();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        // drain, then look for stray results a little longer
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && expected_points.size() == 0)
            $display("** contour_point_smoother_core: PASSED **");
        else
            $display("** contour_point_smoother_core: FAILED **");
        $finish;
    end

endmodule
